/* sv/modexp_pkg.sv */
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int BASE_VALUE_WIDTH = 64;
   localparam int EXPONENT_FIELD_WIDTH = 64;
   localparam int MODULUS_FIELD_WIDTH = 32;
   localparam int RESULT_WIDTH = 32;

   localparam int MODULUS_WIDTH_DEFAULT = 32;
   localparam int EXPONENT_WIDTH_DEFAULT = 64;

endpackage

/* sv/modexp_mulmod.sv */
`timescale 1ns / 1ps

module modexp_mulmod #(
   parameter int MW = 32,
   parameter int BW = 64,
   localparam int CW = $clog2(BW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] op_a,
   input  logic [BW-1:0] op_b,
   input  logic [CW-1:0] bit_count,
   input  logic [MW-1:0] modulus,
   output logic          done,
   output logic [MW-1:0] product
);
   import modexp_pkg::*;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] r_ff, r_in;
   logic [MW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;

   logic [MW:0] mod_ext;
   logic [MW:0] dbl;
   logic [MW:0] dbl_red;
   logic [MW:0] sum;
   logic [MW:0] sum_red;

   // one operand bit per cycle, msb first: r = 2r + bit * a, reduced after each add
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum = dbl_red + {1'b0, (b_ff[BW-1] ? a_ff : {MW{1'b0}})};
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      r_in = r_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = bit_count;
         r_in = '0;
         a_in = op_a;
         b_in = op_b;
      end else if (busy_ff) begin
         r_in = sum_red[MW-1:0];
         b_in = {b_ff[BW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign product = r_ff;

endmodule

/* sv/modular_exponentiation_unit.sv */
// a zero exponent still reduces the base first; then one multiply per set exponent bit and one
// square per bit below the top set bit; a zero modulus skips all of them and gives zero with the
// modulus error flag; the run time is set by the bit-serial modular multiplier
// one item in flight; the next item is taken once the result sits in the output register
// synchronous reset clears the sequencer and the output valid; payload registers are not reset
`timescale 1ns / 1ps

module modular_exponentiation_unit #(
   parameter int MODULUS_WIDTH = modexp_pkg::MODULUS_WIDTH_DEFAULT,
   parameter int EXPONENT_WIDTH = modexp_pkg::EXPONENT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [modexp_pkg::BASE_VALUE_WIDTH-1:0]  req_base_value,
   input  logic [modexp_pkg::EXPONENT_FIELD_WIDTH-1:0] req_exponent,
   input  logic [modexp_pkg::MODULUS_FIELD_WIDTH-1:0]  req_modulus,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [modexp_pkg::RESULT_WIDTH-1:0]      rsp_power_result,
   output logic                                     rsp_modulus_error
);
   import modexp_pkg::*;

   localparam int MW = MODULUS_WIDTH;
   localparam int EW = EXPONENT_WIDTH;
   localparam int BW = BASE_VALUE_WIDTH;
   localparam int CW = $clog2(BW + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_NEXT   = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [MW-1:0] m_ff, m_in;
   logic [EW-1:0] e_ff, e_in;
   logic [MW-1:0] acc_ff, acc_in;
   logic [MW-1:0] base_ff, base_in;
   logic          err_ff, err_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic                    rsp_error_ff, rsp_error_in;

   logic          mm_start;
   logic [MW-1:0] mm_a;
   logic [BW-1:0] mm_b;
   logic [CW-1:0] mm_count;
   logic          mm_done;
   logic [MW-1:0] mm_product;

   logic [MW-1:0] req_m;
   logic          out_free;

   assign req_m = req_modulus[MW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      e_in = e_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_error_in = rsp_error_ff;
      mm_start = 1'b0;
      mm_a = acc_ff;
      mm_b = {base_ff, {(BW - MW){1'b0}}};
      mm_count = CW'(MW);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in = req_m;
               e_in = req_exponent[EW-1:0];
               if (req_m == '0) begin
                  acc_in = '0;
                  err_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  // base mod m: multiply 1 by the full base
                  acc_in = MW'(1);
                  err_in = 1'b0;
                  mm_start = 1'b1;
                  mm_a = MW'(1);
                  mm_b = req_base_value;
                  mm_count = CW'(BW);
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               base_in = mm_product;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (e_ff == '0) begin
               state_in = ST_FINISH;
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               state_in = ST_MULT;
            end else begin
               mm_start = 1'b1;
               mm_a = base_ff;
               e_in = e_ff >> 1;
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mm_done) begin
               acc_in = mm_product;
               e_in = {e_ff[EW-1:1], 1'b0};
               state_in = ST_NEXT;
            end
         end
         ST_SQUARE: begin
            if (mm_done) begin
               base_in = mm_product;
               state_in = ST_NEXT;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = RESULT_WIDTH'(acc_ff);
               rsp_error_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff <= m_in;
      e_ff <= e_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      err_ff <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff <= rsp_error_in;
   end

   modexp_mulmod #(
      .MW(MW),
      .BW(BW)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mm_start),
      .op_a      (mm_a),
      .op_b      (mm_b),
      .bit_count (mm_count),
      .modulus   (m_ff),
      .done      (mm_done),
      .product   (mm_product)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;
   assign rsp_modulus_error = rsp_error_ff;

endmodule
